### rtl/core/hva_pkg.sv
// ----------------------------------------------------------------------------
// hva_pkg
// Shared widths, action and fault codes, payload types and fixed-point
// helpers for the homogeneous tuple ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package hva_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD       = 32;
  localparam int LANES      = 3;
  localparam int COMPS      = 4;
  localparam int ACT_W      = 4;
  localparam int EPS_W      = 16;
  localparam int PROD_W     = 2 * WORD;
  localparam int SUM_W      = PROD_W + 2;
  localparam int RAD_W      = PROD_W;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQ_STAGES  = ROOT_W;
  localparam int SQ_REM_W   = ROOT_W + 4;
  localparam int MAG_W      = ROOT_W + 1;
  localparam int DVS_W      = MAG_W + 1;
  localparam int NUM_W      = WORD + FRAC_BITS + 2;
  localparam int DIV_STAGES = NUM_W;

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);

  localparam logic signed [SUM_W-1:0] ONE_S  = SUM_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic [WORD-1:0] WORD_MAX = {1'b0, {(WORD-1){1'b1}}};
  localparam logic [WORD-1:0] WORD_MIN = {1'b1, {(WORD-1){1'b0}}};

  localparam logic [ACT_W-1:0] ACT_ADD      = 4'd0;
  localparam logic [ACT_W-1:0] ACT_SUB      = 4'd1;
  localparam logic [ACT_W-1:0] ACT_SCALE    = 4'd2;
  localparam logic [ACT_W-1:0] ACT_DIV      = 4'd3;
  localparam logic [ACT_W-1:0] ACT_MAG      = 4'd4;
  localparam logic [ACT_W-1:0] ACT_NORM     = 4'd5;
  localparam logic [ACT_W-1:0] ACT_DOT      = 4'd6;
  localparam logic [ACT_W-1:0] ACT_CROSS    = 4'd7;
  localparam logic [ACT_W-1:0] ACT_ELEM     = 4'd8;
  localparam logic [ACT_W-1:0] ACT_EQUAL    = 4'd9;
  localparam logic [ACT_W-1:0] ACT_CLASSIFY = 4'd10;

  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_SAT  = 2'd1;
  localparam logic [1:0] FLT_DIVZ = 2'd2;

  typedef logic [COMPS-1:0][WORD-1:0] tuple_t;

  typedef struct packed {
    tuple_t           r;
    logic [WORD-1:0]  sc;
    logic             flag;
    logic [1:0]       fault;
  } res_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    res_t             res;
    tuple_t           a;
    logic [WORD-1:0]  s;
    logic             isva;
  } mid_t;

  function automatic logic signed [SUM_W-1:0] sext_word(input logic [WORD-1:0] v);
    return {{(SUM_W-WORD){v[WORD-1]}}, v};
  endfunction

  function automatic logic signed [SUM_W-1:0] sext_prod(input logic [PROD_W-1:0] v);
    return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  function automatic logic [WORD-1:0] abs_word(input logic [WORD-1:0] v);
    return v[WORD-1] ? (~v + WORD'(1)) : v;
  endfunction

  // {overflow, clamped word}
  function automatic logic [WORD:0] sat_word(input logic signed [SUM_W-1:0] v);
    logic            ovf;
    logic [WORD-1:0] val;
    ovf = (v[SUM_W-1:WORD-1] != {(SUM_W-WORD+1){1'b0}}) &&
          (v[SUM_W-1:WORD-1] != {(SUM_W-WORD+1){1'b1}});
    val = ovf ? (v[SUM_W-1] ? WORD_MIN : WORD_MAX) : v[WORD-1:0];
    return {ovf, val};
  endfunction

  // round half up to FRAC_BITS, then clamp
  function automatic logic [WORD:0] round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = (v + HALF_S) >>> FRAC_BITS;
    return sat_word(t);
  endfunction

endpackage

`default_nettype wire

### rtl/core/hva_front.sv
// ----------------------------------------------------------------------------
// hva_front
// Input register, product stage and combine stage: add, subtract, products,
// dot, cross, compare and classify, plus the squared length for the root.
// ----------------------------------------------------------------------------
`default_nettype none

module hva_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  in_valid,
  input  wire logic [hva_pkg::ACT_W-1:0]             action,
  input  wire hva_pkg::tuple_t                       a_in,
  input  wire hva_pkg::tuple_t                       b_in,
  input  wire logic [hva_pkg::WORD-1:0]              s_in,
  input  wire logic [hva_pkg::EPS_W-1:0]             eps,
  output logic                                       out_valid,
  output hva_pkg::mid_t                              mid,
  output logic [hva_pkg::RAD_W-1:0]                  rad
);
  import hva_pkg::*;

  logic                 v1, v2, v3;
  logic [ACT_W-1:0]     act1, act2;
  tuple_t               a1, b1, a2, b2;
  logic [WORD-1:0]      s1, s2;
  logic                 isva2, isvb2;
  logic [PROD_W-1:0]    p2 [2*LANES];

  logic                 isva, isvb;
  logic [WORD-1:0]      ml [2*LANES];
  logic [WORD-1:0]      mr [2*LANES];

  mid_t                 mid_next;
  logic [RAD_W-1:0]     rad_next;

  // hold all stages when the output queue is full
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_comb begin
    isva = {{(WORD-EPS_W){1'b0}}, eps} > abs_word(a1[3]);
    isvb = {{(WORD-EPS_W){1'b0}}, eps} > abs_word(b1[3]);
    for (int i = 0; i < LANES; i++) begin
      ml[i] = (act1 == ACT_CROSS) ? a1[(i+1)%LANES] : a1[i];
      case (act1)
        ACT_SCALE:           mr[i] = s1;
        ACT_MAG, ACT_NORM:   mr[i] = a1[i];
        ACT_CROSS:           mr[i] = b1[(i+2)%LANES];
        default:             mr[i] = b1[i];
      endcase
      ml[LANES+i] = a1[(i+2)%LANES];
      mr[LANES+i] = b1[(i+1)%LANES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1  <= action;
      a1    <= a_in;
      b1    <= b_in;
      s1    <= s_in;
      act2  <= act1;
      a2    <= a1;
      b2    <= b1;
      s2    <= s1;
      isva2 <= isva;
      isvb2 <= isvb;
      for (int i = 0; i < 2*LANES; i++) begin
        p2[i] <= PROD_W'($signed(ml[i]) * $signed(mr[i]));
      end
    end
  end

  logic signed [SUM_W-1:0] ex    [2*LANES];
  logic signed [SUM_W-1:0] sum_v [COMPS];
  logic signed [SUM_W-1:0] dif_v [COMPS];
  logic signed [SUM_W-1:0] w_add, w_sub;
  logic [WORD:0]           add_t [COMPS];
  logic [WORD:0]           sub_t [COMPS];
  logic [WORD:0]           prd_t [LANES];
  logic [WORD:0]           crs_t [LANES];
  logic [WORD:0]           dot_t;
  logic                    sat_any;

  always_comb begin
    for (int i = 0; i < 2*LANES; i++) ex[i] = sext_prod(p2[i]);
    for (int i = 0; i < COMPS; i++) begin
      sum_v[i] = sext_word(a2[i]) + sext_word(b2[i]);
      dif_v[i] = sext_word(a2[i]) - sext_word(b2[i]);
    end
    w_add = (sum_v[3] > ONE_S) ? ONE_S : sum_v[3];
    w_sub = (dif_v[3] < -HALF_S) ? ONE_S : dif_v[3];
    for (int i = 0; i < LANES; i++) begin
      add_t[i] = sat_word(sum_v[i]);
      sub_t[i] = sat_word(dif_v[i]);
      prd_t[i] = round_sat(ex[i]);
      crs_t[i] = round_sat(ex[i] - ex[LANES+i]);
    end
    add_t[3] = sat_word(w_add);
    sub_t[3] = sat_word(w_sub);
    dot_t    = round_sat(ex[0] + ex[1] + ex[2]);
    rad_next = p2[0] + p2[1] + p2[2];

    mid_next        = '0;
    mid_next.action = act2;
    mid_next.a      = a2;
    mid_next.s      = s2;
    mid_next.isva   = isva2;
    sat_any         = 1'b0;

    unique case (act2)
      ACT_ADD: begin
        for (int i = 0; i < COMPS; i++) begin
          mid_next.res.r[i] = add_t[i][WORD-1:0];
          sat_any = sat_any | add_t[i][WORD];
        end
      end
      ACT_SUB: begin
        for (int i = 0; i < COMPS; i++) begin
          mid_next.res.r[i] = sub_t[i][WORD-1:0];
          sat_any = sat_any | sub_t[i][WORD];
        end
      end
      ACT_SCALE: begin
        for (int i = 0; i < LANES; i++) begin
          mid_next.res.r[i] = prd_t[i][WORD-1:0];
          sat_any = sat_any | prd_t[i][WORD];
        end
        mid_next.res.r[3] = a2[3];
      end
      ACT_ELEM: begin
        for (int i = 0; i < LANES; i++) begin
          mid_next.res.r[i] = prd_t[i][WORD-1:0];
          sat_any = sat_any | prd_t[i][WORD];
        end
      end
      ACT_CROSS: begin
        for (int i = 0; i < LANES; i++) begin
          mid_next.res.r[i] = crs_t[i][WORD-1:0];
          sat_any = sat_any | crs_t[i][WORD];
        end
      end
      ACT_DOT: begin
        if (isva2 && isvb2) begin
          mid_next.res.sc = dot_t[WORD-1:0];
          sat_any = dot_t[WORD];
        end
      end
      ACT_EQUAL:    mid_next.res.flag = (a2 == b2);
      ACT_CLASSIFY: mid_next.res.flag = isva2;
      default: ;
    endcase
    mid_next.res.fault = sat_any ? FLT_SAT : FLT_NONE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid <= mid_next;
      rad <= rad_next;
    end
  end

  assign out_valid = v3;

endmodule

`default_nettype wire

### rtl/core/hva_sqrt.sv
// ----------------------------------------------------------------------------
// hva_sqrt
// Pipelined square root, two radicand bits per stage, then a rounding stage
// that gives the root rounded to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module hva_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire hva_pkg::mid_t               in_mid,
  input  wire logic [hva_pkg::RAD_W-1:0]   in_rad,
  output logic                             out_valid,
  output hva_pkg::mid_t                    out_mid,
  output logic [hva_pkg::MAG_W-1:0]        mag
);
  import hva_pkg::*;

  logic                  v_q    [SQ_STAGES+1];
  mid_t                  mid_q  [SQ_STAGES+1];
  logic [RAD_W-1:0]      rad_q  [SQ_STAGES+1];
  logic [SQ_REM_W-1:0]   rem_q  [SQ_STAGES+1];
  logic [ROOT_W-1:0]     root_q [SQ_STAGES+1];

  assign v_q[0]    = in_valid;
  assign mid_q[0]  = in_mid;
  assign rad_q[0]  = in_rad;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic [SQ_REM_W-1:0] t;
    logic [SQ_REM_W-1:0] trial;
    logic                ge;

    always_comb begin
      t     = {rem_q[k][SQ_REM_W-3:0], rad_q[k][RAD_W-1 -: 2]};
      trial = {{(SQ_REM_W-ROOT_W-2){1'b0}}, root_q[k], 2'b01};
      ge    = t >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mid_q[k+1]  <= mid_q[k];
        rad_q[k+1]  <= {rad_q[k][RAD_W-3:0], 2'b00};
        rem_q[k+1]  <= ge ? (t - trial) : t;
        root_q[k+1] <= {root_q[k][ROOT_W-2:0], ge};
      end
    end
  end

  logic [MAG_W-1:0] mag_next;

  always_comb begin
    mag_next = {1'b0, root_q[SQ_STAGES]} +
               MAG_W'(rem_q[SQ_STAGES] > {{(SQ_REM_W-ROOT_W){1'b0}}, root_q[SQ_STAGES]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_q[SQ_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mid <= mid_q[SQ_STAGES];
      mag     <= mag_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hva_div.sv
// ----------------------------------------------------------------------------
// hva_div
// Three-lane pipelined restoring divider for divide and normalize, one
// quotient bit per stage, with round-to-nearest and final result merge.
// ----------------------------------------------------------------------------
`default_nettype none

module hva_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire hva_pkg::mid_t               in_mid,
  input  wire logic [hva_pkg::MAG_W-1:0]   mag,
  output logic                             out_valid,
  output hva_pkg::res_t                    out_res
);
  import hva_pkg::*;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    res_t             res;
    tuple_t           a;
    logic             dz;
    logic             nok;
    logic [LANES-1:0] neg;
  } ctl_t;

  logic              v_q   [DIV_STAGES+1];
  ctl_t              ctl_q [DIV_STAGES+1];
  logic [DVS_W-1:0]  dvs_q [DIV_STAGES+1];
  logic [DVS_W-1:0]  rem_q [DIV_STAGES+1][LANES];
  logic [NUM_W-1:0]  nq_q  [DIV_STAGES+1][LANES];

  ctl_t              ctl_next;
  logic [MAG_W-1:0]  dsel;
  logic [NUM_W-1:0]  num_next [LANES];

  always_comb begin
    ctl_next        = '0;
    ctl_next.action = in_mid.action;
    ctl_next.res    = in_mid.res;
    ctl_next.a      = in_mid.a;
    ctl_next.dz     = (in_mid.s == '0);
    ctl_next.nok    = in_mid.isva && (mag != '0);
    dsel = (in_mid.action == ACT_DIV) ? {1'b0, abs_word(in_mid.s)} : mag;
    for (int i = 0; i < LANES; i++) begin
      ctl_next.neg[i] = in_mid.a[i][WORD-1] ^
                        ((in_mid.action == ACT_DIV) && in_mid.s[WORD-1]);
      num_next[i] = NUM_W'({abs_word(in_mid.a[i]), {(FRAC_BITS+1){1'b0}}}) +
                    NUM_W'(dsel);
    end
    if ((in_mid.action == ACT_MAG) && in_mid.isva) begin
      if (mag[MAG_W-1:WORD-1] != '0) begin
        ctl_next.res.sc    = WORD_MAX;
        ctl_next.res.fault = FLT_SAT;
      end else begin
        ctl_next.res.sc = mag[WORD-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_q[0] <= ctl_next;
      dvs_q[0] <= {dsel, 1'b0};
      for (int i = 0; i < LANES; i++) begin
        rem_q[0][i] <= '0;
        nq_q[0][i]  <= num_next[i];
      end
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_q[k+1] <= ctl_q[k];
        dvs_q[k+1] <= dvs_q[k];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DVS_W:0] t;
      logic [DVS_W:0] diff;
      logic           ge;

      always_comb begin
        t    = {rem_q[k][l], nq_q[k][l][NUM_W-1]};
        diff = t - {1'b0, dvs_q[k]};
        ge   = t >= {1'b0, dvs_q[k]};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k+1][l] <= ge ? diff[DVS_W-1:0] : t[DVS_W-1:0];
          nq_q[k+1][l]  <= {nq_q[k][l][NUM_W-2:0], ge};
        end
      end
    end
  end

  ctl_t                    ctl_l;
  logic signed [SUM_W-1:0] qv  [LANES];
  logic [WORD:0]           q_t [LANES];
  logic                    sat_any;

  always_comb begin
    ctl_l   = ctl_q[DIV_STAGES];
    out_res = ctl_l.res;
    sat_any = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      qv[i]  = SUM_W'(nq_q[DIV_STAGES][i]);
      qv[i]  = ctl_l.neg[i] ? -qv[i] : qv[i];
      q_t[i] = sat_word(qv[i]);
    end
    unique case (ctl_l.action)
      ACT_DIV: begin
        out_res.r[3] = ctl_l.a[3];
        if (ctl_l.dz) begin
          out_res.fault = FLT_DIVZ;
        end else begin
          for (int i = 0; i < LANES; i++) begin
            out_res.r[i] = q_t[i][WORD-1:0];
            sat_any = sat_any | q_t[i][WORD];
          end
          out_res.fault = sat_any ? FLT_SAT : FLT_NONE;
        end
      end
      ACT_NORM: begin
        out_res.r = ctl_l.a;
        if (ctl_l.nok) begin
          for (int i = 0; i < LANES; i++) begin
            out_res.r[i] = q_t[i][WORD-1:0];
            sat_any = sat_any | q_t[i][WORD];
          end
          out_res.fault = sat_any ? FLT_SAT : FLT_NONE;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = v_q[DIV_STAGES];

endmodule

`default_nettype wire

### rtl/core/hva_out_fifo.sv
// ----------------------------------------------------------------------------
// hva_out_fifo
// Two-entry result queue that decouples the pipeline from the output
// handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module hva_out_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire hva_pkg::res_t  push_data,
  input  wire logic           pop,
  output logic                full,
  output logic                valid,
  output hva_pkg::res_t       data
);
  import hva_pkg::*;

  res_t       mem [2];
  logic       wr, rd;
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= 1'b0;
      rd  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wr <= ~wr;
      if (pop)  rd <= ~rd;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr] <= push_data;
  end

  assign valid = (cnt != 2'd0);
  assign full  = (cnt == 2'd2);
  assign data  = mem[rd];

endmodule

`default_nettype wire

### rtl/core/homogeneous_vector_alu.sv
// Pipeline: 88 register stages (3 front, 32 root plus rounding, divider prep plus
// 50 quotient-bit stages, queue).
// Throughput: one beat per cycle; the whole pipeline holds only when the
// two-entry output queue is full.
// Reset: synchronous rst clears all valid bits and the queue and loads
// vector_epsilon with 66.
// ----------------------------------------------------------------------------
// homogeneous_vector_alu
// Fixed-point homogeneous tuple ALU: arithmetic, products, magnitude,
// normalize, divide, compare and classify with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_vector_alu (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [hva_pkg::EPS_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [hva_pkg::ACT_W-1:0]     action,
  input  wire logic [hva_pkg::WORD-1:0]      a_x,
  input  wire logic [hva_pkg::WORD-1:0]      a_y,
  input  wire logic [hva_pkg::WORD-1:0]      a_z,
  input  wire logic [hva_pkg::WORD-1:0]      a_w,
  input  wire logic [hva_pkg::WORD-1:0]      b_x,
  input  wire logic [hva_pkg::WORD-1:0]      b_y,
  input  wire logic [hva_pkg::WORD-1:0]      b_z,
  input  wire logic [hva_pkg::WORD-1:0]      b_w,
  input  wire logic [hva_pkg::WORD-1:0]      scalar_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [hva_pkg::WORD-1:0]           r_x,
  output logic [hva_pkg::WORD-1:0]           r_y,
  output logic [hva_pkg::WORD-1:0]           r_z,
  output logic [hva_pkg::WORD-1:0]           r_w,
  output logic [hva_pkg::WORD-1:0]           scalar_out,
  output logic                               flag,
  output logic [1:0]                         fault
);
  import hva_pkg::*;

  logic [EPS_W-1:0] vector_epsilon;
  logic             en, full;
  tuple_t           a_t, b_t;

  logic             f_valid, s_valid, d_valid;
  mid_t             f_mid, s_mid;
  logic [RAD_W-1:0] f_rad;
  logic [MAG_W-1:0] s_mag;
  res_t             d_res, q_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_epsilon <= EPS_RESET;
    end else if (cfg_write) begin
      vector_epsilon <= cfg_wdata;
    end
  end

  assign en       = ~full;
  assign in_ready = en;

  assign a_t[0] = a_x;
  assign a_t[1] = a_y;
  assign a_t[2] = a_z;
  assign a_t[3] = a_w;
  assign b_t[0] = b_x;
  assign b_t[1] = b_y;
  assign b_t[2] = b_z;
  assign b_t[3] = b_w;

  hva_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .action    (action),
    .a_in      (a_t),
    .b_in      (b_t),
    .s_in      (scalar_in),
    .eps       (vector_epsilon),
    .out_valid (f_valid),
    .mid       (f_mid),
    .rad       (f_rad)
  );

  hva_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_mid    (f_mid),
    .in_rad    (f_rad),
    .out_valid (s_valid),
    .out_mid   (s_mid),
    .mag       (s_mag)
  );

  hva_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .in_mid    (s_mid),
    .mag       (s_mag),
    .out_valid (d_valid),
    .out_res   (d_res)
  );

  hva_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (en & d_valid),
    .push_data (d_res),
    .pop       (out_valid & out_ready),
    .full      (full),
    .valid     (out_valid),
    .data      (q_res)
  );

  assign r_x        = q_res.r[0];
  assign r_y        = q_res.r[1];
  assign r_z        = q_res.r[2];
  assign r_w        = q_res.r[3];
  assign scalar_out = q_res.sc;
  assign flag       = q_res.flag;
  assign fault      = q_res.fault;

endmodule

`default_nettype wire

### rtl/core/hva_checker.sv
// ----------------------------------------------------------------------------
// hva_assert
// Port-level checks for the homogeneous tuple ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hva_assert (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] r_x,
  input wire logic [31:0] r_y,
  input wire logic [31:0] r_z,
  input wire logic        flag,
  input wire logic [1:0]  fault
);
  import hva_pkg::*;

  a_fault_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fault != 2'd3)
    else $error("undefined fault code");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_flag_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && flag |-> fault == FLT_NONE)
    else $error("flag beat carries a fault");

  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault == FLT_DIVZ |-> r_x == 32'd0 && r_y == 32'd0 && r_z == 32'd0)
    else $error("divide by zero beat has nonzero tuple");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(r_x) && $stable(fault))
    else $error("result beat dropped or changed while stalled");

endmodule

bind homogeneous_vector_alu hva_assert u_hva_assert (.*);

`default_nettype wire
